// ===== hdl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, sampled on the rising edge, off while reset is low.
`define ASSERT_RST(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(name, clk, rstn, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

// ===== hdl/lzhd_pkg.sv =====
package lzhd_pkg;

  localparam int unsigned HISTORY_DEPTH = 32768;
  localparam int unsigned HIST_AW       = $clog2(HISTORY_DEPTH);
  localparam int unsigned WC_W          = HIST_AW + 1;
  localparam int unsigned SRC_W         = 16;
  localparam int unsigned REM_W         = 11;

  localparam logic [1:0] MODE_BYTE    = 2'd0;
  localparam logic [1:0] MODE_TICK    = 2'd1;
  localparam logic [1:0] MODE_RESTART = 2'd2;
  localparam logic [1:0] MODE_BAD     = 2'd3;

  localparam logic [2:0] ST_CONSUMED = 3'd0;
  localparam logic [2:0] ST_OUT      = 3'd1;
  localparam logic [2:0] ST_END      = 3'd2;
  localparam logic [2:0] ST_ERROR    = 3'd3;
  localparam logic [2:0] ST_REFUSED  = 3'd4;
  localparam logic [2:0] ST_IDLE     = 3'd5;

  localparam logic [2:0] CT_LITERAL = 3'd0;
  localparam logic [2:0] CT_FILL    = 3'd1;
  localparam logic [2:0] CT_ALT     = 3'd2;
  localparam logic [2:0] CT_ZERO    = 3'd3;
  localparam logic [2:0] CT_BACK    = 3'd4;
  localparam logic [2:0] CT_BITREV  = 3'd5;
  localparam logic [2:0] CT_REVBACK = 3'd6;
  localparam logic [2:0] CT_EXT     = 3'd7;

  localparam logic [7:0] END_MARKER = 8'hff;

  typedef enum logic [3:0] {
    PH_CMD,
    PH_EXTLEN,
    PH_FILL,
    PH_ALT1,
    PH_ALT2,
    PH_OFSHI,
    PH_OFSLO,
    PH_LITERAL,
    PH_EXPAND
  } phase_e;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] in_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       run_last;
    logic [2:0] status;
  } result_t;

  // What the controller decides for one transfer.
  typedef struct packed {
    logic               rd_en;
    logic [HIST_AW-1:0] rd_addr;
    logic               we;
    logic               from_mem;
    logic               rev;
    logic [HIST_AW-1:0] waddr;
    result_t            res;
  } step_t;

  // Result stage: waits for the registered history read data.
  typedef struct packed {
    logic               we;
    logic               from_mem;
    logic               rev;
    logic [HIST_AW-1:0] waddr;
    result_t            res;
  } s1_t;

endpackage

// ===== hdl/lzhd_ram.sv =====
module lzhd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Same-address read and write return the old word.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/lzhd_ctrl.sv =====
module lzhd_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  lzhd_pkg::item_t item_i,
  output lzhd_pkg::step_t step_o
);
  import lzhd_pkg::*;

  phase_e            phase_q, phase_d;
  logic [WC_W-1:0]   wc_q, wc_d;
  logic [2:0]        ctype_q, ctype_d;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [SRC_W-1:0]  src_q, src_d;
  logic [7:0]        ff_q, ff_d;
  logic [7:0]        fs_q, fs_d;
  logic              alt_q, alt_d;
  logic              fin_q, fin_d;
  logic              err_q, err_d;

  logic              do_emit;
  logic              mem_src;
  logic [7:0]        emit_byte;
  logic [REM_W-1:0]  rem_dec;
  logic [SRC_W-1:0]  wc_ext;
  logic [7:0]        b;

  function automatic phase_e run_phase(input logic [2:0] ct);
    phase_e ph;
    unique case (ct)
      CT_LITERAL: ph = PH_LITERAL;
      CT_FILL:    ph = PH_FILL;
      CT_ALT:     ph = PH_ALT1;
      CT_ZERO:    ph = PH_EXPAND;
      default:    ph = PH_OFSHI;
    endcase
    return ph;
  endfunction

  assign b       = item_i.in_byte;
  assign wc_ext  = SRC_W'(wc_q);
  assign rem_dec = rem_q - REM_W'(1);

  always_comb begin
    phase_d   = phase_q;
    wc_d      = wc_q;
    ctype_d   = ctype_q;
    rem_d     = rem_q;
    src_d     = src_q;
    ff_d      = ff_q;
    fs_d      = fs_q;
    alt_d     = alt_q;
    fin_d     = fin_q;
    err_d     = err_q;
    do_emit   = 1'b0;
    mem_src   = 1'b0;
    emit_byte = '0;
    step_o            = '0;
    step_o.rd_addr    = src_q[HIST_AW-1:0];
    step_o.waddr      = wc_q[HIST_AW-1:0];
    step_o.rev        = (ctype_q == CT_BITREV);
    step_o.res.status = ST_CONSUMED;

    if (item_i.mode == MODE_RESTART) begin
      phase_d = PH_CMD;
      wc_d    = '0;
      ctype_d = '0;
      rem_d   = '0;
      src_d   = '0;
      ff_d    = '0;
      fs_d    = '0;
      alt_d   = 1'b0;
      fin_d   = 1'b0;
      err_d   = 1'b0;
    end else if (item_i.mode == MODE_BAD) begin
      step_o.res.status = ST_REFUSED;
    end else if (err_q) begin
      step_o.res.status = ST_ERROR;
    end else if (fin_q) begin
      step_o.res.status = (item_i.mode == MODE_BYTE) ? ST_REFUSED : ST_IDLE;
    end else if (item_i.mode == MODE_BYTE) begin
      unique case (phase_q)
        PH_CMD: begin
          if (b == END_MARKER) begin
            fin_d             = 1'b1;
            step_o.res.status = ST_END;
          end else if (b[7:5] == CT_EXT) begin
            ctype_d = b[4:2];
            rem_d   = REM_W'(b[1:0]);
            if (b[4:2] == CT_EXT) begin
              err_d             = 1'b1;
              step_o.res.status = ST_ERROR;
            end else begin
              phase_d = PH_EXTLEN;
            end
          end else begin
            ctype_d = b[7:5];
            rem_d   = REM_W'(b[4:0]) + REM_W'(1);
            alt_d   = 1'b0;
            phase_d = run_phase(b[7:5]);
          end
        end
        PH_EXTLEN: begin
          rem_d   = {1'b0, rem_q[1:0], b} + REM_W'(1);
          alt_d   = 1'b0;
          phase_d = run_phase(ctype_q);
        end
        PH_FILL: begin
          ff_d    = b;
          phase_d = PH_EXPAND;
        end
        PH_ALT1: begin
          ff_d    = b;
          phase_d = PH_ALT2;
        end
        PH_ALT2: begin
          fs_d    = b;
          phase_d = PH_EXPAND;
        end
        PH_OFSHI: begin
          if (b[7]) begin
            // short form: distance back from the write pointer
            src_d   = wc_ext - SRC_W'(b[6:0]) - SRC_W'(1);
            phase_d = PH_EXPAND;
          end else begin
            src_d   = {1'b0, b[6:0], 8'h00};
            phase_d = PH_OFSLO;
          end
        end
        PH_OFSLO: begin
          src_d   = src_q | SRC_W'(b);
          phase_d = PH_EXPAND;
        end
        PH_LITERAL: begin
          do_emit   = 1'b1;
          emit_byte = b;
        end
        default: begin
          step_o.res.status = ST_REFUSED;
        end
      endcase
    end else begin
      if (phase_q != PH_EXPAND) begin
        step_o.res.status = ST_IDLE;
      end else if (ctype_q[2]) begin
        if (src_q >= wc_ext) begin
          err_d             = 1'b1;
          step_o.res.status = ST_ERROR;
        end else begin
          do_emit = 1'b1;
          mem_src = 1'b1;
          src_d   = (ctype_q == CT_REVBACK) ? src_q - SRC_W'(1) : src_q + SRC_W'(1);
        end
      end else begin
        do_emit = 1'b1;
        case (ctype_q)
          CT_FILL: emit_byte = ff_q;
          CT_ALT: begin
            emit_byte = alt_q ? fs_q : ff_q;
            alt_d     = ~alt_q;
          end
          default: emit_byte = '0;
        endcase
      end
    end

    if (do_emit) begin
      if (wc_q >= WC_W'(HISTORY_DEPTH)) begin
        err_d             = 1'b1;
        step_o.res.status = ST_ERROR;
      end else begin
        wc_d                 = wc_q + WC_W'(1);
        rem_d                = rem_dec;
        step_o.we            = 1'b1;
        step_o.rd_en         = mem_src;
        step_o.from_mem      = mem_src;
        step_o.res.out_byte  = emit_byte;
        step_o.res.out_valid = 1'b1;
        step_o.res.run_last  = (rem_dec == '0);
        step_o.res.status    = ST_OUT;
        if (rem_dec == '0) begin
          phase_d = PH_CMD;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_CMD;
      wc_q    <= '0;
      ctype_q <= '0;
      rem_q   <= '0;
      src_q   <= '0;
      ff_q    <= '0;
      fs_q    <= '0;
      alt_q   <= 1'b0;
      fin_q   <= 1'b0;
      err_q   <= 1'b0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      wc_q    <= wc_d;
      ctype_q <= ctype_d;
      rem_q   <= rem_d;
      src_q   <= src_d;
      ff_q    <= ff_d;
      fs_q    <= fs_d;
      alt_q   <= alt_d;
      fin_q   <= fin_d;
      err_q   <= err_d;
    end
  end

endmodule

// ===== hdl/lz_history_decompressor_top.sv =====
// LZ history decompressor. Takes one item per cycle while item_stall_o is low:
// a compressed byte, a tick that pulls the next expanded byte of a fill or copy
// run, or a restart. Every item gives exactly one result, through the result
// stage and the output register. Stream state is decoded at the input transfer;
// the expanded bytes live in a 32768 x 8 history RAM with one write and one
// registered read port. A back-copy tick reads the RAM in its transfer cycle,
// and the byte is written back the cycle after and then moves to the output
// register; when a copy reads the byte the previous item is just writing, that
// byte is forwarded around the RAM. Reads of history positions not yet written
// in the current stream are flagged as errors, so the RAM needs no clearing
// after reset or restart. Input stall rises only when both the result stage
// and the output register are held by a stalled output.
module lz_history_decompressor_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              item_valid_i,
  output logic              item_stall_o,
  input  lzhd_pkg::item_t   item_i,
  output logic              result_valid_o,
  input  logic              result_stall_i,
  output lzhd_pkg::result_t result_o
);
  import lzhd_pkg::*;
  `include "assert_macros.svh"

  step_t              step;
  logic               in_acc;
  logic               s1_adv;
  logic               s1_valid_q;
  logic               s1_fresh_q;
  s1_t                s1_q;
  logic               hit_d, hit_q;
  logic [7:0]         fwd_q;
  logic [7:0]         ram_rdata;
  logic [7:0]         mem_byte;
  logic [7:0]         proc_byte;
  logic [7:0]         s1_byte;
  logic               ram_we;
  logic               ram_re;
  logic               out_valid_q;
  result_t            out_q;

  function automatic logic [7:0] reverse_bits(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = v[7-i];
    end
    return r;
  endfunction

  lzhd_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(in_acc),
    .item_i  (item_i),
    .step_o  (step)
  );

  assign s1_adv       = !out_valid_q || !result_stall_i;
  assign item_stall_o = s1_valid_q && !s1_adv;
  assign in_acc       = item_valid_i && !item_stall_o;

  assign mem_byte  = hit_q ? fwd_q : ram_rdata;
  assign proc_byte = s1_q.rev ? reverse_bits(mem_byte) : mem_byte;
  assign s1_byte   = (s1_fresh_q && s1_q.from_mem) ? proc_byte : s1_q.res.out_byte;

  assign ram_we = s1_valid_q && s1_fresh_q && s1_q.we;
  assign ram_re = in_acc && step.rd_en;
  // copy source is the byte being written this cycle
  assign hit_d  = step.rd_en && ram_we && (step.rd_addr == s1_q.waddr);

  lzhd_ram #(
    .Width(8),
    .Depth(HISTORY_DEPTH)
  ) u_hist (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(s1_q.waddr),
    .wdata_i(s1_byte),
    .re_i   (ram_re),
    .raddr_i(step.rd_addr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s1_fresh_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
        s1_fresh_q <= 1'b1;
      end else begin
        s1_fresh_q <= 1'b0;
        if (s1_adv) begin
          s1_valid_q <= 1'b0;
        end
      end
      if (s1_adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q.we       <= step.we;
      s1_q.from_mem <= step.from_mem;
      s1_q.rev      <= step.rev;
      s1_q.waddr    <= step.waddr;
      s1_q.res      <= step.res;
      hit_q         <= hit_d;
      fwd_q         <= s1_byte;
    end else if (s1_fresh_q) begin
      // RAM read data is not selected after this cycle
      s1_q.res.out_byte <= s1_byte;
    end
    if (s1_adv && s1_valid_q) begin
      out_q <= result_t'{out_byte:  s1_byte,
                         out_valid: s1_q.res.out_valid,
                         run_last:  s1_q.res.run_last,
                         status:    s1_q.res.status};
    end
  end

  assign result_valid_o = out_valid_q;
  assign result_o       = out_q;

  `ASSERT_RST(a_stall_cause, clk_i, rst_ni,
              item_stall_o |-> (s1_valid_q && out_valid_q && result_stall_i),
              "input stall without a held result")
  `ASSERT_RST(a_read_lands, clk_i, rst_ni,
              ram_re |=> (s1_valid_q && s1_fresh_q && s1_q.from_mem),
              "history read data not taken by result stage")
  `ASSERT_RST(a_write_once, clk_i, rst_ni,
              ram_we |-> $past(in_acc),
              "history write repeated from a held result")

endmodule
